@@ hdl/ppmfd_pkg.sv @@
// Shared types and constants of the PPM frame decoder.
package ppmfd_pkg;

    localparam int CH_N    = 8;
    localparam int CH_IX_W = 3;
    localparam int WID_W   = 14;
    localparam int TIME_W  = 32;
    localparam int CNT_W   = 32;
    localparam int ACC_W   = 17;
    localparam int DEN_W   = 33;
    localparam int ALU_W   = 34;
    localparam int TDATA_W = 200;
    localparam int CFG_IX_W = 3;

    // Quotient bits of the accuracy division, one per step
    localparam int DIV_STEPS = ACC_W;
    localparam int DIV_CNT_W = 5;

    // Register indexes of the configuration port
    localparam logic [CFG_IX_W-1:0] REG_MIN_GAP   = 3'd0;
    localparam logic [CFG_IX_W-1:0] REG_MAX_GAP   = 3'd1;
    localparam logic [CFG_IX_W-1:0] REG_SYNC_MIN  = 3'd2;
    localparam logic [CFG_IX_W-1:0] REG_PULSE_MIN = 3'd3;
    localparam logic [CFG_IX_W-1:0] REG_PULSE_MAX = 3'd4;

    // Reset values of the thresholds, microseconds
    localparam logic [WID_W-1:0] RST_MIN_GAP   = 14'd600;
    localparam logic [WID_W-1:0] RST_MAX_GAP   = 14'd12500;
    localparam logic [WID_W-1:0] RST_SYNC_MIN  = 14'd2500;
    localparam logic [WID_W-1:0] RST_PULSE_MIN = 14'd800;
    localparam logic [WID_W-1:0] RST_PULSE_MAX = 14'd2200;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAP,
        S_CHK_MIN,
        S_CHK_MAX,
        S_SYNC,
        S_PMIN,
        S_PMAX,
        S_MISS,
        S_GOOD,
        S_DEN,
        S_DIV,
        S_OUT
    } state_t;

endpackage

@@ hdl/ppmfd_alu.sv @@
// Shared add/subtract unit; the top bit of the result is carry or borrow.
module ppmfd_alu (
    input  ppmfd_pkg::alu_op_t             op,
    input  logic [ppmfd_pkg::ALU_W-1:0]    a,
    input  logic [ppmfd_pkg::ALU_W-1:0]    b,
    output logic [ppmfd_pkg::ALU_W:0]      res
);

    // Extend by one bit so carry out and borrow land in the top bit
    always_comb
    begin
        case (op)
            ppmfd_pkg::ALU_ADD: res = {1'b0, a} + {1'b0, b};
            ppmfd_pkg::ALU_SUB: res = {1'b0, a} - {1'b0, b};
            default:            res = {1'b0, a};
        endcase
    end

endmodule

@@ hdl/ppm_frame_decoder.sv @@
// Top level of the PPM frame decoder: sequencer around one shared add/subtract unit.
//
//  channel  | direction | payload
//  s_axis   | in        | edge timestamp, 32 bits
//  m_axis   | out       | eight channel widths, frame counters, accuracy
//  cfg      | in        | threshold registers, write only
//
// An edge is taken while the sequencer is idle; every compare, count and division
// step then runs through the single add/subtract unit, one operation per cycle.
// Every edge keeps s_axis_tready low until the sequencer has ignored it, opened
// a frame on it, stored it or dropped the frame; the edge that completes a frame
// also runs the bit-serial division and waits for a free output register.
// Reset clears the sequencer, the counters, the frame state and the thresholds
// to their defaults. A result waiting on m_axis stalls the next frame result and s_axis.
module ppm_frame_decoder (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ppmfd_pkg::TIME_W-1:0]       s_axis_tdata,   // [31:0] edge_time

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [13:0] ch0_width, [27:14] ch1_width, [41:28] ch2_width, [55:42] ch3_width,
    // [69:56] ch4_width, [83:70] ch5_width, [97:84] ch6_width, [111:98] ch7_width,
    // [143:112] good_frames, [175:144] missed_frames, [192:176] accuracy, zeros above
    output logic [ppmfd_pkg::TDATA_W-1:0]      m_axis_tdata,

    input  logic                               cfg_we,
    input  logic [ppmfd_pkg::CFG_IX_W-1:0]     cfg_index,
    input  logic [ppmfd_pkg::WID_W-1:0]        cfg_data
);

    ppmfd_pkg::state_t                  state_reg, state_next;
    logic [ppmfd_pkg::TIME_W-1:0]       now_reg, now_next;
    logic [ppmfd_pkg::TIME_W-1:0]       prev_reg, prev_next;
    logic [ppmfd_pkg::TIME_W-1:0]       gap_reg, gap_next;
    logic                               in_frame_reg, in_frame_next;
    logic [ppmfd_pkg::CH_IX_W-1:0]      chan_reg, chan_next;
    logic [ppmfd_pkg::CNT_W-1:0]        good_reg, good_next;
    logic [ppmfd_pkg::CNT_W-1:0]        miss_reg, miss_next;
    logic [ppmfd_pkg::DEN_W-1:0]        den_reg, den_next;
    logic [ppmfd_pkg::DEN_W-1:0]        rem_reg, rem_next;
    logic [ppmfd_pkg::ACC_W-1:0]        quo_reg, quo_next;
    logic [ppmfd_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                               out_valid_reg, out_valid_next;
    logic [ppmfd_pkg::TDATA_W-1:0]      out_data_reg, out_data_next;
    logic                               out_load;

    logic [ppmfd_pkg::WID_W-1:0]        min_gap_reg, max_gap_reg, sync_min_reg;
    logic [ppmfd_pkg::WID_W-1:0]        pulse_min_reg, pulse_max_reg;

    logic [ppmfd_pkg::WID_W-1:0]        chan_store_reg [ppmfd_pkg::CH_N];
    logic                               store_we;

    ppmfd_pkg::alu_op_t                 alu_op;
    logic [ppmfd_pkg::ALU_W-1:0]        alu_a, alu_b;
    logic [ppmfd_pkg::ALU_W:0]          alu_res;
    logic                               alu_borrow;
    logic                               div_bit;

    ppmfd_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign alu_borrow    = alu_res[ppmfd_pkg::ALU_W];
    assign div_bit       = (cnt_reg == ppmfd_pkg::DIV_CNT_W'(ppmfd_pkg::DIV_STEPS - 1))
                           ? good_reg[0] : 1'b0;
    assign s_axis_tready = (state_reg == ppmfd_pkg::S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Sequence one edge through the shared unit
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        prev_next      = prev_reg;
        gap_next       = gap_reg;
        in_frame_next  = in_frame_reg;
        chan_next      = chan_reg;
        good_next      = good_reg;
        miss_next      = miss_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_load       = 1'b0;
        store_we       = 1'b0;
        alu_op         = ppmfd_pkg::ALU_SUB;
        alu_a          = '0;
        alu_b          = '0;

        case (state_reg)
            ppmfd_pkg::S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    now_next   = s_axis_tdata;
                    state_next = ppmfd_pkg::S_GAP;
                end
            end

            // Gap since the last edge, modulo 2^32
            ppmfd_pkg::S_GAP:
            begin
                alu_a      = {2'b00, now_reg};
                alu_b      = {2'b00, prev_reg};
                gap_next   = alu_res[ppmfd_pkg::TIME_W-1:0];
                prev_next  = now_reg;
                state_next = ppmfd_pkg::S_CHK_MIN;
            end

            // Drop glitches
            ppmfd_pkg::S_CHK_MIN:
            begin
                alu_a      = {2'b00, gap_reg};
                alu_b      = {20'd0, min_gap_reg};
                state_next = alu_borrow ? ppmfd_pkg::S_IDLE : ppmfd_pkg::S_CHK_MAX;
            end

            // Drop PWM-length gaps
            ppmfd_pkg::S_CHK_MAX:
            begin
                alu_a = {20'd0, max_gap_reg};
                alu_b = {2'b00, gap_reg};
                if (alu_borrow)
                    state_next = ppmfd_pkg::S_IDLE;
                else if (in_frame_reg)
                    state_next = ppmfd_pkg::S_PMIN;
                else
                    state_next = ppmfd_pkg::S_SYNC;
            end

            // Open a frame on a sync gap
            ppmfd_pkg::S_SYNC:
            begin
                alu_a = {2'b00, gap_reg};
                alu_b = {20'd0, sync_min_reg};
                if (!alu_borrow)
                begin
                    in_frame_next = 1'b1;
                    chan_next     = '0;
                end
                state_next = ppmfd_pkg::S_IDLE;
            end

            // Abort on a gap at or below pulse_min
            ppmfd_pkg::S_PMIN:
            begin
                alu_a      = {20'd0, pulse_min_reg};
                alu_b      = {2'b00, gap_reg};
                state_next = alu_borrow ? ppmfd_pkg::S_PMAX : ppmfd_pkg::S_MISS;
            end

            // Abort on a gap above pulse_max, else store the channel
            ppmfd_pkg::S_PMAX:
            begin
                alu_a = {20'd0, pulse_max_reg};
                alu_b = {2'b00, gap_reg};
                if (alu_borrow)
                    state_next = ppmfd_pkg::S_MISS;
                else
                begin
                    store_we = 1'b1;
                    if (chan_reg == ppmfd_pkg::CH_IX_W'(ppmfd_pkg::CH_N - 1))
                        state_next = ppmfd_pkg::S_GOOD;
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = ppmfd_pkg::S_IDLE;
                    end
                end
            end

            // Count a miss, saturating
            ppmfd_pkg::S_MISS:
            begin
                alu_op = ppmfd_pkg::ALU_ADD;
                alu_a  = {2'b00, miss_reg};
                alu_b  = ppmfd_pkg::ALU_W'(1);
                if (!alu_res[ppmfd_pkg::CNT_W])
                    miss_next = alu_res[ppmfd_pkg::CNT_W-1:0];
                in_frame_next = 1'b0;
                chan_next     = '0;
                state_next    = ppmfd_pkg::S_IDLE;
            end

            // Count a good frame, saturating
            ppmfd_pkg::S_GOOD:
            begin
                alu_op = ppmfd_pkg::ALU_ADD;
                alu_a  = {2'b00, good_reg};
                alu_b  = ppmfd_pkg::ALU_W'(1);
                if (!alu_res[ppmfd_pkg::CNT_W])
                    good_next = alu_res[ppmfd_pkg::CNT_W-1:0];
                in_frame_next = 1'b0;
                chan_next     = '0;
                state_next    = ppmfd_pkg::S_DEN;
            end

            // Form good + missed and seed the divider with good >> 1
            ppmfd_pkg::S_DEN:
            begin
                alu_op     = ppmfd_pkg::ALU_ADD;
                alu_a      = {2'b00, good_reg};
                alu_b      = {2'b00, miss_reg};
                den_next   = alu_res[ppmfd_pkg::DEN_W-1:0];
                rem_next   = {2'b00, good_reg[ppmfd_pkg::CNT_W-1:1]};
                quo_next   = '0;
                cnt_next   = ppmfd_pkg::DIV_CNT_W'(ppmfd_pkg::DIV_STEPS - 1);
                state_next = ppmfd_pkg::S_DIV;
            end

            // One restoring division step: quotient bit from the borrow
            ppmfd_pkg::S_DIV:
            begin
                alu_a    = {rem_reg, div_bit};
                alu_b    = {1'b0, den_reg};
                rem_next = alu_borrow ? alu_a[ppmfd_pkg::DEN_W-1:0]
                                      : alu_res[ppmfd_pkg::DEN_W-1:0];
                quo_next = {quo_reg[ppmfd_pkg::ACC_W-2:0], ~alu_borrow};
                if (cnt_reg == '0)
                    state_next = ppmfd_pkg::S_OUT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            // Hand the result to the output register once it is free
            ppmfd_pkg::S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ppmfd_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ppmfd_pkg::S_IDLE;
            end
        endcase
    end

    // Pack the result beat
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < ppmfd_pkg::CH_N; i++)
            out_data_next[i*ppmfd_pkg::WID_W +: ppmfd_pkg::WID_W] = chan_store_reg[i];
        out_data_next[112 +: ppmfd_pkg::CNT_W] = good_reg;
        out_data_next[144 +: ppmfd_pkg::CNT_W] = miss_reg;
        out_data_next[176 +: ppmfd_pkg::ACC_W] = quo_reg;
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppmfd_pkg::S_IDLE;
            prev_reg      <= '0;
            in_frame_reg  <= 1'b0;
            chan_reg      <= '0;
            good_reg      <= '0;
            miss_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            in_frame_reg  <= in_frame_next;
            chan_reg      <= chan_next;
            good_reg      <= good_next;
            miss_reg      <= miss_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        gap_reg <= gap_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (out_load)
            out_data_reg <= out_data_next;
        if (store_we)
            chan_store_reg[chan_reg] <= gap_reg[ppmfd_pkg::WID_W-1:0];
    end

    // Threshold registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg   <= ppmfd_pkg::RST_MIN_GAP;
            max_gap_reg   <= ppmfd_pkg::RST_MAX_GAP;
            sync_min_reg  <= ppmfd_pkg::RST_SYNC_MIN;
            pulse_min_reg <= ppmfd_pkg::RST_PULSE_MIN;
            pulse_max_reg <= ppmfd_pkg::RST_PULSE_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppmfd_pkg::REG_MIN_GAP:   min_gap_reg   <= cfg_data;
                ppmfd_pkg::REG_MAX_GAP:   max_gap_reg   <= cfg_data;
                ppmfd_pkg::REG_SYNC_MIN:  sync_min_reg  <= cfg_data;
                ppmfd_pkg::REG_PULSE_MIN: pulse_min_reg <= cfg_data;
                ppmfd_pkg::REG_PULSE_MAX: pulse_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule
